FILE: rtl/core/kfts_pkg.sv
// Shared types and constants for the key frequency table.
// Used by the table cell, the top level and the port checker.
package kfts_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned USE_W   = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned DATA_W  = KEY_W + COUNT_W;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_NEW   = 3'd1,
    ST_FULL  = 3'd2,
    ST_READ  = 3'd3,
    ST_EMPTY = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_COUNT = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  // Contents of one table slot as it moves around the ring.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
    logic               valid;
    logic               done;
  } cell_data_t;

  // Commands broadcast to every slot.
  typedef struct packed {
    logic rotate;
    logic count_en;
    logic clear_done;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/kfts_cell.sv
// One slot of the frequency table: key, count, valid and readout-done flag.
// Depends on kfts_pkg; instantiated in a ring by the top level.
module kfts_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kfts_pkg::cell_ctrl_t             ctrl_i,
  input  logic [kfts_pkg::KEY_W-1:0]       key_i,
  input  logic                             append_i,
  input  logic                             mark_i,
  input  kfts_pkg::cell_data_t             nb_i,
  output kfts_pkg::cell_data_t             data_o,
  output logic                             hit_o,
  output logic [kfts_pkg::COUNT_W-1:0]     count_next_o
);

  logic [kfts_pkg::KEY_W-1:0]   key_q;
  logic [kfts_pkg::COUNT_W-1:0] count_q;
  logic                         valid_q;
  logic                         done_q;

  assign hit_o        = ctrl_i.count_en && valid_q && (key_q == key_i);
  assign count_next_o = (&count_q) ? count_q : count_q + kfts_pkg::COUNT_W'(1);

  assign data_o.key   = key_q;
  assign data_o.count = count_q;
  assign data_o.valid = valid_q;
  assign data_o.done  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else if (ctrl_i.rotate) begin
      valid_q <= nb_i.valid;
      done_q  <= nb_i.done | mark_i;
    end else if (ctrl_i.clear_done) begin
      done_q <= 1'b0;
    end else if (append_i) begin
      valid_q <= 1'b1;
      done_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rotate) begin
      key_q   <= nb_i.key;
      count_q <= nb_i.count;
    end else if (append_i) begin
      key_q   <= key_i;
      count_q <= kfts_pkg::COUNT_W'(1);
    end else if (hit_o) begin
      count_q <= count_next_o;
    end
  end

endmodule

FILE: rtl/core/key_frequency_table_sorted_readout.sv
// Top level of the key frequency table with sorted readout.
// Depends on kfts_pkg and kfts_cell.
//
// Usage: input beats arrive on the s_axis channel. tuser selects the
// operation (0 counts one occurrence of the key in tdata, 1 reads the
// table out) and tdata carries the 16-bit key. Every count beat yields one
// result beat on m_axis: tuser holds the status (hit, new entry, table
// full), tdata holds the key and the count after the update, and tlast is
// set. Count beats are taken one per cycle while the output register is
// free; all slots compare the key in parallel; the result is registered.
//
// A readout beat yields one result per used entry, largest count first,
// equal counts in order of first insertion, tlast on the final beat; an
// empty table yields a single beat with the empty status. The slots form a
// ring that rotates by one position per cycle while a comparator at the
// head picks the largest entry not yet sent. No input is taken during a
// readout. The table is left unchanged.
//
// Reset empties the table at once. When the receiver holds tready low, the
// result stays in the output register and further input waits.
module key_frequency_table_sorted_readout (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] key
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [15:0] out_key, [47:16] out_count
  output logic [2:0]  m_axis_tuser_o,   // [2:0] status
  output logic        m_axis_tlast_o
);

  localparam int unsigned N = kfts_pkg::ENTRIES;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e                         state_q;
  logic [kfts_pkg::USE_W-1:0]     used_q;
  logic [kfts_pkg::USE_W-1:0]     emitted_q;
  logic [kfts_pkg::IDX_W-1:0]     pos_q;
  logic [kfts_pkg::IDX_W-1:0]     best_pos_q;
  logic [kfts_pkg::IDX_W-1:0]     mark_pos_q;
  logic                           mark_en_q;
  logic                           best_valid_q;
  logic [kfts_pkg::KEY_W-1:0]     best_key_q;
  logic [kfts_pkg::COUNT_W-1:0]   best_count_q;

  logic                           m_valid_q;
  kfts_pkg::status_e              m_status_q;
  logic [kfts_pkg::KEY_W-1:0]     m_key_q;
  logic [kfts_pkg::COUNT_W-1:0]   m_count_q;
  logic                           m_last_q;

  kfts_pkg::cell_ctrl_t           ctrl;
  kfts_pkg::cell_data_t           cell_data [N];
  logic [N-1:0]                   hit_vec;
  logic [N-1:0]                   append_sel;
  logic [kfts_pkg::COUNT_W-1:0]   cell_next [N];
  logic [kfts_pkg::COUNT_W-1:0]   hit_count;

  logic                           out_free;
  logic                           accept;
  logic                           is_count;
  logic                           any_hit;
  logic                           table_full;
  logic                           mark_now;
  logic                           candidate;
  logic                           take;
  logic                           last_pos;
  logic [kfts_pkg::USE_W-1:0]     emitted_next;
  logic                           final_beat;
  kfts_pkg::cell_data_t           head;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_count        = accept && (s_axis_tuser_i == kfts_pkg::FUNC_COUNT);
  assign any_hit         = |hit_vec;
  assign table_full      = (used_q == kfts_pkg::USE_W'(N));

  // The head slot is examined once per cycle while the ring rotates.
  assign head      = cell_data[0];
  assign last_pos  = (pos_q == kfts_pkg::IDX_W'(N - 1));
  assign mark_now  = mark_en_q && (pos_q == mark_pos_q);
  assign candidate = head.valid && !head.done && !mark_now;
  // Strict compare keeps the earliest inserted entry on equal counts.
  assign take      = candidate && (!best_valid_q || (head.count > best_count_q));

  assign emitted_next = emitted_q + kfts_pkg::USE_W'(1);
  assign final_beat   = (emitted_next == used_q);

  assign ctrl.rotate     = (state_q == S_SCAN);
  assign ctrl.count_en   = is_count;
  assign ctrl.clear_done = (state_q == S_EMIT) && out_free && final_beat;

  // Keys in the table are distinct, so at most one slot hits.
  always_comb begin
    hit_count = '0;
    for (int i = 0; i < N; i++) begin
      append_sel[i] = is_count && !any_hit && (used_q == kfts_pkg::USE_W'(i));
      if (hit_vec[i]) begin
        hit_count = hit_count | cell_next[i];
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic mark_in;
    if (g == N - 1) begin : g_tail
      assign mark_in = ctrl.rotate && mark_now;
    end else begin : g_body
      assign mark_in = 1'b0;
    end

    kfts_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (s_axis_tdata_i),
      .append_i     (append_sel[g]),
      .mark_i       (mark_in),
      .nb_i         (cell_data[(g + 1) % N]),
      .data_o       (cell_data[g]),
      .hit_o        (hit_vec[g]),
      .count_next_o (cell_next[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      emitted_q    <= '0;
      pos_q        <= '0;
      best_pos_q   <= '0;
      mark_pos_q   <= '0;
      mark_en_q    <= 1'b0;
      best_valid_q <= 1'b0;
      best_key_q   <= '0;
      best_count_q <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= kfts_pkg::ST_HIT;
      m_key_q      <= '0;
      m_count_q    <= '0;
      m_last_q     <= 1'b0;
    end else begin
      if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (is_count) begin
            m_valid_q <= 1'b1;
            m_key_q   <= s_axis_tdata_i;
            m_last_q  <= 1'b1;
            if (any_hit) begin
              m_status_q <= kfts_pkg::ST_HIT;
              m_count_q  <= hit_count;
            end else if (!table_full) begin
              m_status_q <= kfts_pkg::ST_NEW;
              m_count_q  <= kfts_pkg::COUNT_W'(1);
              used_q     <= used_q + kfts_pkg::USE_W'(1);
            end else begin
              m_status_q <= kfts_pkg::ST_FULL;
              m_count_q  <= '0;
            end
          end else if (accept) begin
            if (used_q == '0) begin
              m_valid_q  <= 1'b1;
              m_status_q <= kfts_pkg::ST_EMPTY;
              m_key_q    <= '0;
              m_count_q  <= '0;
              m_last_q   <= 1'b1;
            end else begin
              state_q      <= S_SCAN;
              pos_q        <= '0;
              best_valid_q <= 1'b0;
              mark_en_q    <= 1'b0;
              emitted_q    <= '0;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            best_valid_q <= 1'b1;
            best_key_q   <= head.key;
            best_count_q <= head.count;
            best_pos_q   <= pos_q;
          end
          if (last_pos) begin
            pos_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            pos_q <= pos_q + kfts_pkg::IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_valid_q  <= 1'b1;
            m_status_q <= kfts_pkg::ST_READ;
            m_key_q    <= best_key_q;
            m_count_q  <= best_count_q;
            m_last_q   <= final_beat;
            if (final_beat) begin
              state_q   <= S_IDLE;
              mark_en_q <= 1'b0;
            end else begin
              state_q      <= S_SCAN;
              mark_en_q    <= 1'b1;
              mark_pos_q   <= best_pos_q;
              best_valid_q <= 1'b0;
              emitted_q    <= emitted_next;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {m_count_q, m_key_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

FILE: rtl/core/kfts_checker.sv
// Port-level checks for the key frequency table, bound to the top level.
// Depends on kfts_pkg for the status and function codes.
module kfts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // Input is taken only when the output register can take the result.
  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready while output register is blocked");

  // A count beat yields its result in the next cycle.
  a_count_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o &&
     (s_axis_tuser_i == kfts_pkg::FUNC_COUNT)) |=>
    (m_axis_tvalid_o && m_axis_tlast_o && m_axis_tdata_o[15:0] == $past(s_axis_tdata_i)))
    else $error("count result missing or wrong key");

  // Only readout entries may be non-final; new entries start at one.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != kfts_pkg::ST_READ)) |-> m_axis_tlast_o)
    else $error("non-readout result without last");

  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == kfts_pkg::ST_NEW)) |->
    (m_axis_tdata_o[47:16] == 32'd1))
    else $error("new entry with count other than one");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
    (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind key_frequency_table_sorted_readout kfts_checker u_kfts_checker (.*);
